### design/tcs_pkg.sv
// Shared types, constants and helpers for the triangle colour span shader.
`default_nettype none
package tcs_pkg;

  // Sizing constants.
  localparam int MAX_SPAN   = 64;
  localparam int COORD_BITS = 12;
  localparam int CNT_W      = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int ACC_W      = 64;
  localparam int UV_W       = 42;
  localparam int BX_W       = COORD_BITS + 2;
  localparam int MB_W       = (BX_W > 17) ? BX_W : 17;
  localparam int PROD_W     = UV_W + MB_W;

  localparam logic signed [ACC_W-1:0] UV_LIMIT = ACC_W'(64'sd1 <<< 40);
  localparam logic signed [ACC_W-1:0] ONE_Q32  = ACC_W'(64'sd1 <<< 32);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_U   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_V   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MAP_OFS = 3'd5;

  // Datapath operations issued by the controller.
  typedef enum logic [2:0] {
    OP_NONE, OP_UX, OP_UY, OP_VX, OP_VY, OP_SAT, OP_CHAN
  } op_t;

  // Sub-operations of a colour channel setup.
  localparam logic [1:0] SUB_ACC_U  = 2'd0;
  localparam logic [1:0] SUB_ACC_V  = 2'd1;
  localparam logic [1:0] SUB_STEP_U = 2'd2;
  localparam logic [1:0] SUB_STEP_V = 2'd3;

  typedef struct packed {
    logic [11:0]      start_x;
    logic [11:0]      row_y;
    logic [CNT_W-1:0] pixel_count;
  } in_word_t;

  typedef struct packed {
    logic [31:0] pixel;
    logic        last;
  } out_word_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;
    op_t        op;
    logic [1:0] chan;
    logic [1:0] sub;
    logic       pix;
    logic       pix_last;
  } tcs_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pipe_busy;
  } tcs_stat_t;

  // Clamp an accumulator to [0,1] and truncate to Q.16.
  function automatic logic [16:0] to_q16(logic signed [ACC_W-1:0] a);
    logic [16:0] r;
    if (a < 0) begin
      r = '0;
    end else if (a > ONE_Q32) begin
      r = 17'h10000;
    end else begin
      r = a[32:16];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### design/tcs_ctrl.sv
// Controller that sequences span setup and per-pixel issue.
`default_nettype none
module tcs_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [tcs_pkg::CNT_W-1:0] count,
  input  wire tcs_pkg::tcs_stat_t    stat,
  output logic                       busy,
  output tcs_pkg::tcs_cmd_t          cmd
);
  import tcs_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_RUN, ST_DRAIN} state_t;

  localparam logic [4:0] LAST_OP = 5'd20;

  state_t           state_r, state_nxt;
  logic [4:0]       op_r, op_nxt;
  logic [CNT_W-1:0] rem_r, rem_nxt;
  logic [CNT_W-1:0] cnt_sat;
  logic [4:0]       chan_op;

  assign busy    = (state_r != ST_IDLE);
  assign cnt_sat = (count > CNT_W'(MAX_SPAN)) ? CNT_W'(MAX_SPAN) : count;
  assign chan_op = op_r - 5'd5;

  // Next state and command decode.
  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    rem_nxt      = rem_r;
    cmd          = '0;
    cmd.op       = OP_NONE;
    case (state_r)
      ST_IDLE: begin
        if (start && (count != '0)) begin
          cmd.load  = 1'b1;
          rem_nxt   = cnt_sat;
          op_nxt    = '0;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        case (op_r)
          5'd0:    cmd.op = OP_UX;
          5'd1:    cmd.op = OP_UY;
          5'd2:    cmd.op = OP_VX;
          5'd3:    cmd.op = OP_VY;
          5'd4:    cmd.op = OP_SAT;
          default: begin
            cmd.op   = OP_CHAN;
            cmd.chan = chan_op[3:2];
            cmd.sub  = chan_op[1:0];
          end
        endcase
        op_nxt = op_r + 5'd1;
        if (op_r == LAST_OP) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.pix      = 1'b1;
        cmd.pix_last = (rem_r == CNT_W'(1));
        rem_nxt      = rem_r - CNT_W'(1);
        if (rem_r == CNT_W'(1)) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and counters.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= '0;
      rem_r   <= '0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      rem_r   <= rem_nxt;
    end
  end

endmodule
`default_nettype wire

### design/tcs_datapath.sv
// Datapath: configuration registers, shared multiplier, accumulators and pixel pipeline.
`default_nettype none
module tcs_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [tcs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [tcs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  wire tcs_pkg::in_word_t            in_word,
  input  wire tcs_pkg::tcs_cmd_t            cmd,
  output tcs_pkg::tcs_stat_t                stat,
  output logic                              out_valid,
  output tcs_pkg::out_word_t                out_word
);
  import tcs_pkg::*;

  logic [63:0] v0_r, v1_r, v2_r, mu_r, mv_r, mo_r;
  logic signed [BX_W-1:0]   bx_r, by_r;
  logic signed [ACC_W-1:0]  ua_r, va_r;
  logic signed [UV_W-1:0]   u_r, v_r;
  logic signed [ACC_W-1:0]  acc_r [4];
  logic signed [ACC_W-1:0]  stp_r [4];

  logic signed [31:0] ux, uy, vx, vy, uo, vo;
  logic [COORD_BITS-1:0] cx, cy;
  logic signed [16:0] d1, d2;
  logic signed [UV_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_x;

  logic        pa_vld_r, pa_last_r;
  logic [16:0] pa_c_r [4];
  logic        pb_vld_r, pb_last_r;
  logic [33:0] pb_p_r [3];
  logic [7:0]  pb_a8_r;
  logic [24:0] a_mul;
  logic [41:0] c_mul [3];
  logic [41:0] c_rnd [3];

  assign ux = signed'(mu_r[63:32]);
  assign uy = signed'(mu_r[31:0]);
  assign vx = signed'(mv_r[63:32]);
  assign vy = signed'(mv_r[31:0]);
  assign uo = signed'(mo_r[63:32]);
  assign vo = signed'(mo_r[31:0]);
  assign cx = COORD_BITS'(in_word.start_x);
  assign cy = COORD_BITS'(in_word.row_y);

  // Colour differences of the selected channel.
  assign d1 = signed'({1'b0, v1_r[16*cmd.chan +: 16]}) - signed'({1'b0, v0_r[16*cmd.chan +: 16]});
  assign d2 = signed'({1'b0, v2_r[16*cmd.chan +: 16]}) - signed'({1'b0, v0_r[16*cmd.chan +: 16]});

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      OP_UX: begin mul_a = UV_W'(ux); mul_b = MB_W'(bx_r); end
      OP_UY: begin mul_a = UV_W'(uy); mul_b = MB_W'(by_r); end
      OP_VX: begin mul_a = UV_W'(vx); mul_b = MB_W'(bx_r); end
      OP_VY: begin mul_a = UV_W'(vy); mul_b = MB_W'(by_r); end
      OP_CHAN: begin
        case (cmd.sub)
          SUB_ACC_U:  begin mul_a = u_r;        mul_b = MB_W'(d1); end
          SUB_ACC_V:  begin mul_a = v_r;        mul_b = MB_W'(d2); end
          SUB_STEP_U: begin mul_a = UV_W'(ux);  mul_b = MB_W'(d1); end
          default:    begin mul_a = UV_W'(vx);  mul_b = MB_W'(d2); end
        endcase
      end
      default: ;
    endcase
  end

  assign prod   = mul_a * mul_b;
  assign prod_x = ACC_W'(prod);

  // Configuration register file.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= '0; v1_r <= '0; v2_r <= '0;
      mu_r <= '0; mv_r <= '0; mo_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_VERTEX0: v0_r <= cfg_wdata;
        CFG_VERTEX1: v1_r <= cfg_wdata;
        CFG_VERTEX2: v2_r <= cfg_wdata;
        CFG_MAP_U:   mu_r <= cfg_wdata;
        CFG_MAP_V:   mv_r <= cfg_wdata;
        CFG_MAP_OFS: mo_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Setup accumulation and span stepping.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bx_r <= signed'({1'b0, cx, 1'b1});
      by_r <= signed'({1'b0, cy, 1'b1});
      ua_r <= ACC_W'(uo) <<< 1;
      va_r <= ACC_W'(vo) <<< 1;
      for (int k = 0; k < 4; k++) begin
        acc_r[k] <= signed'(ACC_W'({v0_r[16*k +: 16], 17'b0}));
        stp_r[k] <= '0;
      end
    end else begin
      case (cmd.op)
        OP_UX, OP_UY: ua_r <= ua_r + prod_x;
        OP_VX, OP_VY: va_r <= va_r + prod_x;
        OP_SAT: begin
          u_r <= (ua_r > UV_LIMIT) ? UV_W'(UV_LIMIT) :
                 (ua_r < -UV_LIMIT) ? UV_W'(-UV_LIMIT) : UV_W'(ua_r);
          v_r <= (va_r > UV_LIMIT) ? UV_W'(UV_LIMIT) :
                 (va_r < -UV_LIMIT) ? UV_W'(-UV_LIMIT) : UV_W'(va_r);
        end
        OP_CHAN: begin
          if (cmd.sub == SUB_ACC_U || cmd.sub == SUB_ACC_V) begin
            acc_r[cmd.chan] <= acc_r[cmd.chan] + prod_x;
          end else begin
            stp_r[cmd.chan] <= stp_r[cmd.chan] + prod_x;
          end
        end
        default: begin
          if (cmd.pix) begin
            for (int k = 0; k < 4; k++) begin
              acc_r[k] <= acc_r[k] + (stp_r[k] <<< 1);
            end
          end
        end
      endcase
    end
  end

  // Pixel stage A: clamp each channel to Q.16.
  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      pa_c_r[k] <= to_q16(acc_r[k]);
    end
    pa_last_r <= cmd.pix_last;
  end

  // Pixel stage B: premultiply colour by alpha and round alpha.
  assign a_mul = {pa_c_r[3], 8'b0} - 25'(pa_c_r[3]);
  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      pb_p_r[k] <= 34'(pa_c_r[k]) * 34'(pa_c_r[3]);
    end
    pb_a8_r   <= 8'((a_mul + 25'd32768) >> 16);
    pb_last_r <= pa_last_r;
  end

  // Pixel stage C: scale by 255, round and pack.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      c_mul[k] = {pb_p_r[k], 8'b0} - 42'(pb_p_r[k]);
      c_rnd[k] = c_mul[k] + 42'h0_8000_0000;
    end
  end
  always_ff @(posedge clk) begin
    out_word.pixel <= {pb_a8_r, c_rnd[2][39:32], c_rnd[1][39:32], c_rnd[0][39:32]};
    out_word.last  <= pb_last_r;
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pa_vld_r  <= 1'b0;
      pb_vld_r  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pa_vld_r  <= cmd.pix;
      pb_vld_r  <= pa_vld_r;
      out_valid <= pb_vld_r;
    end
  end

  assign stat.pipe_busy = pa_vld_r | pb_vld_r;

endmodule
`default_nettype wire

### design/triangle_color_span_shader.sv
// Top level of the Gouraud triangle colour span shader.
`default_nettype none
// A span is taken when start is high and busy is low. Setup runs on one shared
// multiplier; then the span's pixels leave one per cycle, each on out_word for a
// single cycle with out_valid high and last set on the final one. Each pixel passes
// through stage A, stage B and the output register. The receiver cannot stall. A
// count of zero is not taken and gives no word; counts above 64 give 64 pixels.
// Write configuration only while busy is low and no word is still due.
module triangle_color_span_shader (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire tcs_pkg::in_word_t              in_word,
  output logic                                out_valid,
  output tcs_pkg::out_word_t                  out_word,
  input  wire logic                           cfg_we,
  input  wire logic [tcs_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [tcs_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tcs_pkg::*;

  tcs_cmd_t  cmd;
  tcs_stat_t stat;

  // Sequencer.
  tcs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .count (in_word.pixel_count),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Arithmetic and pixel pipeline.
  tcs_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_word   (in_word),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

  // The last word of a span is never directly followed by another word.
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.last |=> !out_valid)
    else $error("word followed the last word of a span");

  // A non-empty span request makes the block busy.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_word.pixel_count != '0) |=> busy)
    else $error("span accepted without going busy");

  // A new span never begins while a word of the previous one is still out.
  a_clean_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> !out_valid)
    else $error("span started with a word still out");

endmodule
`default_nettype wire
